// ----- rtl/core/sbkt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbkt_pkg: shared definitions for the sorted byte key table
// Table size, key width, operation and status codes, and the structs that
// pass between the cell row and the control logic.
// ----------------------------------------------------------------------------
package sbkt_pkg;

    // table geometry
    localparam int DEPTH    = 256;
    localparam int KEY_BITS = 8;

    // select tree: cells per first-level group and group count
    localparam int GRP  = 16;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    // operation codes
    localparam logic [2:0] FN_EXACT = 3'd0;
    localparam logic [2:0] FN_GE    = 3'd1;
    localparam logic [2:0] FN_LE    = 3'd2;
    localparam logic [2:0] FN_INS   = 3'd3;
    localparam logic [2:0] FN_DEL   = 3'd4;
    localparam logic [2:0] FN_CLR   = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // write command broadcast to every cell
    typedef struct packed {
        logic                ins;
        logic                del;
        logic [KEY_BITS-1:0] key;
    } t_cmd;

    // partial select results of one cell group
    typedef struct packed {
        logic       hit;
        logic       any_ge;
        logic [7:0] key_ge;
        logic [7:0] pos_bnd;
        logic       any_le;
        logic [7:0] key_le;
        logic [7:0] pos_le;
    } t_part;

endpackage

// ----- rtl/core/sbkt_req_if.sv -----
// ----------------------------------------------------------------------------
// sbkt_req_if: request channel
// Valid/ready channel carrying one operation code and one key per word.
// ----------------------------------------------------------------------------
interface sbkt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// ----- rtl/core/sbkt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sbkt_rsp_if: response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface sbkt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       found;
    logic [7:0] position;
    logic [7:0] entry_key;
    logic [8:0] entries_used;

    modport source (output valid, output status, output found, output position,
                    output entry_key, output entries_used, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input entry_key, input entries_used, output ready);
endinterface

// ----- rtl/core/sorted_byte_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_byte_key_table: sorted table of distinct byte keys
// Exact, greater-or-equal and less-or-equal lookup, sorted insert, delete
// and clear over a row of compare-and-shift cells.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+------------------------------------
//   i_req    | in  | valid / ready    | func, key
//   o_rsp    | out | valid / ready    | status, found, position, entry_key,
//            |     |                  | entries_used
//
// Each request passes three steps: flag capture in the cells at accept, a
// registered group select level, then the final select with the shift.
// A new request can be taken in the cycle after the previous result is registered,
// even while that result waits in the output register.
// Reset clears the entry count; key slots are filled only by inserts.
// A stalled output holds the finishing request in its last step.
// ----------------------------------------------------------------------------
module sorted_byte_key_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbkt_req_if.sink   i_req,
    sbkt_rsp_if.source o_rsp
);
    import sbkt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RED,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [2:0]          r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [8:0]          r_count;
    logic                r_out_vld;
    logic [1:0]          r_status;
    logic                r_found;
    logic [7:0]          r_pos;
    logic [7:0]          r_ekey;
    logic [8:0]          r_used;

    logic [1:0]          n_status;
    logic                n_found;
    logic [7:0]          n_pos;
    logic [7:0]          n_ekey;
    logic [8:0]          n_count;

    logic                accept;
    logic                go;
    logic                full;
    logic [DEPTH-1:0]    vld;
    t_part               part [NGRP];
    t_part               tot;
    t_cmd                cmd;

    assign accept = i_req.valid && i_req.ready;
    assign go     = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);
    assign full   = (r_count >= 9'(DEPTH));

    // occupied slots
    for (genvar i = 0; i < DEPTH; i++) begin : g_vld
        assign vld[i] = (9'(i) < r_count);
    end

    // shift command, issued once as the request finishes
    always_comb begin
        cmd.key = r_key;
        cmd.ins = go && (r_func == FN_INS) && !tot.hit && !full;
        cmd.del = go && (r_func == FN_DEL) && tot.hit;
    end

    sbkt_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (accept),
        .i_key   (i_req.key[KEY_BITS-1:0]),
        .i_vld   (vld),
        .i_cmd   (cmd),
        .o_part  (part)
    );

    // second select level
    always_comb begin
        tot = '0;
        for (int g = 0; g < NGRP; g++) begin
            tot = tot | part[g];
        end
    end

    // result word and new count
    always_comb begin
        n_status = ST_DONE;
        n_found  = 1'b0;
        n_pos    = '0;
        n_ekey   = '0;
        n_count  = r_count;
        unique case (r_func)
            FN_EXACT: begin
                if (tot.hit) begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_bnd;
                    n_ekey  = 8'(r_key);
                end else begin
                    n_status = ST_MISS;
                end
            end
            FN_GE: begin
                if (tot.any_ge) begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_bnd;
                    n_ekey  = tot.key_ge;
                end else begin
                    n_status = ST_MISS;
                end
            end
            FN_LE: begin
                if (tot.hit) begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_bnd;
                    n_ekey  = 8'(r_key);
                end else if (tot.any_le) begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_le;
                    n_ekey  = tot.key_le;
                end else begin
                    n_status = ST_MISS;
                end
            end
            FN_INS: begin
                if (tot.hit) begin
                    n_status = ST_MISS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_bnd;
                    n_ekey  = 8'(r_key);
                    n_count = r_count + 9'd1;
                end
            end
            FN_DEL: begin
                if (tot.hit) begin
                    n_found = 1'b1;
                    n_pos   = tot.pos_bnd;
                    n_ekey  = 8'(r_key);
                    n_count = r_count - 9'd1;
                end else begin
                    n_status = ST_MISS;
                end
            end
            FN_CLR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // sequencer, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // output word: a finishing request refills it, a taken word empties it
            if (go) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_RED;
                        r_func  <= i_req.func;
                        r_key   <= i_req.key[KEY_BITS-1:0];
                    end
                end
                S_RED: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (go) begin
                        r_state   <= S_IDLE;
                        r_count   <= n_count;
                        r_status  <= n_status;
                        r_found   <= n_found;
                        r_pos     <= n_pos;
                        r_ekey    <= n_ekey;
                        r_used    <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_status;
    assign o_rsp.found        = r_found;
    assign o_rsp.position     = r_pos;
    assign o_rsp.entry_key    = r_ekey;
    assign o_rsp.entries_used = r_used;

    // count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(DEPTH))
        else $error("entry count exceeds table depth");

    // count moves by at most one, or drops to zero on clear
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 9'd1)
              || (r_count == $past(r_count) - 9'd1) || (r_count == 9'd0))
        else $error("entry count jumped");

    // an accepted request reaches the select step
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RED) ##1 (r_state == S_FIN))
        else $error("request sequence broken");

    // a returned entry always reports done
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (o_rsp.status == ST_DONE))
        else $error("found entry with failure status");

    // the table only changes as a request finishes
    a_shift_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> $stable(r_count))
        else $error("count changed outside finishing step");

endmodule

// ----- rtl/core/sbkt_cell.sv -----
// ----------------------------------------------------------------------------
// sbkt_cell: one table slot
// Holds one key, compares it with the request key and shifts keys to or
// from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sbkt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cap,
    input  logic [sbkt_pkg::KEY_BITS-1:0] i_key,
    input  logic                          i_vld,
    input  logic                          i_lt_left,
    input  logic [sbkt_pkg::KEY_BITS-1:0] i_key_left,
    input  logic [sbkt_pkg::KEY_BITS-1:0] i_key_right,
    input  sbkt_pkg::t_cmd                i_cmd,
    output logic                          o_lt,
    output logic                          o_eq,
    output logic [sbkt_pkg::KEY_BITS-1:0] o_key
);
    import sbkt_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_lt;
    logic                r_eq;

    // compare flags, captured when a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_cap) begin
            r_lt <= i_vld && (r_key < i_key);
            r_eq <= i_vld && (r_key == i_key);
        end
    end

    // insert: slots at or above the boundary move up, boundary takes new key
    // delete: slots at or above the hit pull from the right
    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && !r_lt) begin
            n_key = i_lt_left ? i_cmd.key : i_key_left;
        end else if (i_cmd.del && !r_lt) begin
            n_key = i_key_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_key = r_key;

endmodule

// ----- rtl/core/sbkt_row.sv -----
// ----------------------------------------------------------------------------
// sbkt_row: chain of table cells with the first select level
// Wires each cell to its neighbors and reduces per-cell selections into
// registered group results.
// ----------------------------------------------------------------------------
module sbkt_row (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cap,
    input  logic [sbkt_pkg::KEY_BITS-1:0] i_key,
    input  logic [sbkt_pkg::DEPTH-1:0]    i_vld,
    input  sbkt_pkg::t_cmd                i_cmd,
    output sbkt_pkg::t_part               o_part [sbkt_pkg::NGRP]
);
    import sbkt_pkg::*;

    logic [DEPTH-1:0]    lt;
    logic [DEPTH-1:0]    eq;
    logic [DEPTH-1:0]    bnd;
    logic [DEPTH-1:0]    sel_ge;
    logic [DEPTH-1:0]    sel_le;
    logic [KEY_BITS-1:0] keys [DEPTH];
    t_part               n_part [NGRP];
    t_part               r_part [NGRP];

    // cell chain; the first cell sees a virtual lower key on its left
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                lt_left;
        logic                lt_right;
        logic [KEY_BITS-1:0] key_left;
        logic [KEY_BITS-1:0] key_right;

        if (i == 0) begin : g_first
            assign lt_left  = 1'b1;
            assign key_left = '0;
        end else begin : g_mid_l
            assign lt_left  = lt[i-1];
            assign key_left = keys[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign lt_right  = 1'b0;
            assign key_right = '0;
        end else begin : g_mid_r
            assign lt_right  = lt[i+1];
            assign key_right = keys[i+1];
        end

        sbkt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cap       (i_cap),
            .i_key       (i_key),
            .i_vld       (i_vld[i]),
            .i_lt_left   (lt_left),
            .i_key_left  (key_left),
            .i_key_right (key_right),
            .i_cmd       (i_cmd),
            .o_lt        (lt[i]),
            .o_eq        (eq[i]),
            .o_key       (keys[i])
        );

        // boundary is the first slot not below the key
        assign bnd[i]    = lt_left && !lt[i];
        assign sel_ge[i] = bnd[i] && i_vld[i];
        assign sel_le[i] = lt[i] && !lt_right;
    end

    // first select level: OR over each group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH) begin
                    n_part[g].hit    |= eq[g*GRP+j];
                    n_part[g].any_ge |= sel_ge[g*GRP+j];
                    n_part[g].any_le |= sel_le[g*GRP+j];
                    if (sel_ge[g*GRP+j]) begin
                        n_part[g].key_ge |= 8'(keys[g*GRP+j]);
                    end
                    if (bnd[g*GRP+j]) begin
                        n_part[g].pos_bnd |= 8'(g * GRP + j);
                    end
                    if (sel_le[g*GRP+j]) begin
                        n_part[g].key_le |= 8'(keys[g*GRP+j]);
                        n_part[g].pos_le |= 8'(g * GRP + j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
    end

    assign o_part = r_part;

endmodule
